FILE: rtl/core/mcbd_pkg.sv
`timescale 1ns / 1ps
// Package for the mip chain box downsampler: widths, register indexes,
// shared types. No dependencies.
package mcbd_pkg;

  localparam int CH_W      = 16;
  localparam int MAX_CH    = 4;
  localparam int LVL_W     = 4;
  localparam int TXY_W     = 11;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_DIM    = 4096;
  localparam int DEF_MAX_LEVELS = 13;
  localparam int DEF_CHANNELS   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef logic [MAX_CH-1:0][CH_W-1:0] chan_vec_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [TXY_W-1:0] x;
    logic [TXY_W-1:0] y;
    chan_vec_t        ch;
    logic             final_texel;
  } res_t;

  typedef struct packed {
    logic emit;
    logic done;
  } cell_stat_t;

endpackage

FILE: rtl/core/mcbd_if.sv
`timescale 1ns / 1ps
// Channel interfaces: texel input, result output, configuration write.
// Depends on mcbd_pkg.
interface mcbd_in_if import mcbd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] chan_red;
  logic [CH_W-1:0] chan_green;
  logic [CH_W-1:0] chan_blue;
  logic [CH_W-1:0] chan_alpha;
  modport source (output valid, chan_red, chan_green, chan_blue, chan_alpha, input ready);
  modport sink (input valid, chan_red, chan_green, chan_blue, chan_alpha, output ready);
endinterface

interface mcbd_out_if import mcbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] mip_level;
  logic [TXY_W-1:0] texel_x;
  logic [TXY_W-1:0] texel_y;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;
  logic [CH_W-1:0]  out_alpha;
  logic             final_texel;
  modport source (output valid, mip_level, texel_x, texel_y, out_red, out_green, out_blue,
                  out_alpha, final_texel, input ready);
  modport sink (input valid, mip_level, texel_x, texel_y, out_red, out_green, out_blue,
                out_alpha, final_texel, output ready);
endinterface

interface mcbd_cfg_if import mcbd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

FILE: rtl/core/mcbd_cell.sv
`timescale 1ns / 1ps
// One mip level of the cascade: position, left texel, pair-sum row memory.
// Depends on mcbd_pkg.
module mcbd_cell import mcbd_pkg::*; #(
  parameter int IDX      = 0,
  parameter int MAX_DIM  = DEF_MAX_DIM,
  parameter int CHANNELS = DEF_CHANNELS,
  parameter bit LAST     = 1'b0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clr_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]   img_w_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]   img_h_i,
  input  logic                           tok_valid_i,
  input  chan_vec_t                      tok_tex_i,
  input  logic                           next_will_emit_i,
  input  logic                           slot_free_i,
  output logic                           will_emit_o,
  output logic                           tok_valid_o,
  output chan_vec_t                      tok_tex_o,
  output res_t                           res_o,
  output cell_stat_t                     stat_o
);

  localparam int DIM_W = $clog2(MAX_DIM+1);
  localparam int POS_W = $clog2(MAX_DIM);
  localparam int DEPTH = ((MAX_DIM/2) >> IDX) > 0 ? ((MAX_DIM/2) >> IDX) : 1;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int PW    = CH_W + 1;
  localparam int MW    = CHANNELS * PW;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t                         state_r, state_nxt;
  logic [POS_W-1:0]               x_r, y_r;
  chan_vec_t                      left_r;
  logic [MW-1:0]                  mem [DEPTH];
  logic [MW-1:0]                  rd_r;
  logic [MW-1:0]                  pair_r;
  logic [POS_W-1:0]               dx_r, dy_r;
  logic                           sh1_r;
  logic                           tok_valid_r;
  chan_vec_t                      tok_tex_r;

  logic [DIM_W-1:0] sw_raw, sh_raw, sw, sh, sw_even, sh_even, maxd, xe, ye;
  logic             active, sw_one, sh_one, h_in, v_in, h_emit, v_emit;
  logic             tok_a, fire, left_wr, store_wr;
  logic [POS_W-1:0] dx, dy;
  logic [AW-1:0]    addr;
  logic [MW-1:0]    pair_vec;
  chan_vec_t        avg;
  logic [PW:0]      sum;

  always_comb begin
    sw_raw  = img_w_i >> IDX;
    sh_raw  = img_h_i >> IDX;
    sw      = (sw_raw == '0) ? DIM_W'(1) : sw_raw;
    sh      = (sh_raw == '0) ? DIM_W'(1) : sh_raw;
    maxd    = (img_w_i > img_h_i) ? img_w_i : img_h_i;
    active  = (maxd >> (IDX + 1)) != '0;
    sw_one  = sw == DIM_W'(1);
    sh_one  = sh == DIM_W'(1);
    sw_even = {sw[DIM_W-1:1], 1'b0};
    sh_even = {sh[DIM_W-1:1], 1'b0};
    xe      = DIM_W'(x_r);
    ye      = DIM_W'(y_r);
    h_in    = !sw_one && (xe < sw_even);
    v_in    = !sh_one && (ye < sh_even);
    h_emit  = sw_one || (h_in && x_r[0]);
    v_emit  = sh_one || (v_in && y_r[0]);
    will_emit_o = active && h_emit && v_emit;
    tok_a   = tok_valid_i && (state_r == S_IDLE);
    fire    = (state_r == S_EMIT) && slot_free_i;
    left_wr = tok_a && active && h_in && !x_r[0];
    store_wr = tok_a && active && h_emit && v_in && !y_r[0];
    dx      = sw_one ? '0 : (x_r >> 1);
    dy      = sh_one ? '0 : (y_r >> 1);
    addr    = dx[AW-1:0];
    for (int c = 0; c < CHANNELS; c++) begin
      pair_vec[c*PW +: PW] = sw_one ? {tok_tex_i[c], 1'b0}
                                    : {1'b0, left_r[c]} + {1'b0, tok_tex_i[c]};
    end
    avg = '0;
    sum = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      sum = sh1_r ? {pair_r[c*PW +: PW], 1'b0}
                  : {1'b0, rd_r[c*PW +: PW]} + {1'b0, pair_r[c*PW +: PW]};
      avg[c] = sum[PW:2];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (tok_a && will_emit_o) state_nxt = S_EMIT;
      S_EMIT: if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      x_r         <= '0;
      y_r         <= '0;
      tok_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tok_valid_r <= fire;
      if (clr_i) begin
        x_r <= '0;
        y_r <= '0;
      end else if (tok_a && active) begin
        if ((xe + DIM_W'(1)) >= sw) begin
          x_r <= '0;
          y_r <= ((ye + DIM_W'(1)) >= sh) ? '0 : y_r + POS_W'(1);
        end else begin
          x_r <= x_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (left_wr) left_r <= tok_tex_i;
    if (store_wr) mem[addr] <= pair_vec;
    if (tok_a) begin
      rd_r   <= mem[addr];
      pair_r <= pair_vec;
      dx_r   <= dx;
      dy_r   <= dy;
      sh1_r  <= sh_one;
    end
    if (fire) tok_tex_r <= avg;
  end

  assign tok_valid_o       = tok_valid_r;
  assign tok_tex_o         = tok_tex_r;
  assign res_o.level       = LVL_W'(IDX + 1);
  assign res_o.x           = TXY_W'(dx_r);
  assign res_o.y           = TXY_W'(dy_r);
  assign res_o.ch          = avg;
  assign res_o.final_texel = !next_will_emit_i;
  assign stat_o.emit       = fire;
  assign stat_o.done       = (tok_a && !will_emit_o) || (fire && LAST);

endmodule

FILE: rtl/core/mip_chain_box_downsample_rgba_unit.sv
`timescale 1ns / 1ps
// Top level of the mip chain box downsampler: config, cell chain, output register.
// Depends on mcbd_pkg, mcbd_if, mcbd_cell.
//
//  channel  dir  payload                                           handshake
//  in_ch    in   chan_red/green/blue/alpha                         valid/ready
//  out_ch   out  mip_level, texel_x/y, out_red..alpha, final_texel valid/ready
//  cfg_ch   in   reg_index, wr_data                                valid/ready
//
// One texel at a time; the texel is registered on acceptance, and each level cell
// that emits registers its pair-sum memory read, then passes the averaged texel
// through a register to the next cell and to the output register.
// in_ch.ready drops from acceptance until the chain reports done.
// A stalled out_ch holds the emitting cell; synchronous reset clears positions.
module mip_chain_box_downsample_rgba_unit import mcbd_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int MAX_LEVELS = DEF_MAX_LEVELS,
  parameter int CHANNELS   = DEF_CHANNELS
) (
  input  logic        clk,
  input  logic        rst_n,
  mcbd_in_if.sink     in_ch,
  mcbd_out_if.source  out_ch,
  mcbd_cfg_if.sink    cfg_ch
);

  localparam int DIM_W = $clog2(MAX_DIM+1);
  localparam int NC    = MAX_LEVELS - 1;

  logic [DIM_W-1:0] img_w_r, img_h_r, clamp_v;
  logic             busy_r, tok0_r, out_valid_r, cfg_wr, slot_free;
  chan_vec_t        tex0_r, in_tex;
  res_t             out_r, res_sel;
  logic [31:0]      cfg_v;

  logic       tok_valid [NC+1];
  chan_vec_t  tok_tex   [NC+1];
  logic       will_emit [NC+1];
  res_t       res       [NC];
  cell_stat_t stat      [NC];
  logic [NC-1:0] emit_v, done_v;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;
  assign in_ch.ready  = !busy_r;
  assign slot_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    cfg_v = 32'(cfg_ch.wr_data);
    if (cfg_v == 32'd0) clamp_v = DIM_W'(1);
    else if (cfg_v > 32'(MAX_DIM)) clamp_v = DIM_W'(MAX_DIM);
    else clamp_v = DIM_W'(cfg_v);
  end

  always_comb begin
    in_tex = '0;
    if (CHANNELS > 0) in_tex[0] = in_ch.chan_red;
    if (CHANNELS > 1) in_tex[1] = in_ch.chan_green;
    if (CHANNELS > 2) in_tex[2] = in_ch.chan_blue;
    if (CHANNELS > 3) in_tex[3] = in_ch.chan_alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r     <= DIM_W'(1);
      img_h_r     <= DIM_W'(1);
      busy_r      <= 1'b0;
      tok0_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_ch.reg_index)
          REG_IMAGE_WIDTH:  img_w_r <= clamp_v;
          REG_IMAGE_HEIGHT: img_h_r <= clamp_v;
          default: ;
        endcase
      end
      tok0_r <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) busy_r <= 1'b1;
      else if (|done_v) busy_r <= 1'b0;
      if (|emit_v) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) tex0_r <= in_tex;
    if (|emit_v) out_r <= res_sel;
  end

  assign tok_valid[0] = tok0_r;
  assign tok_tex[0]   = tex0_r;
  assign will_emit[NC] = 1'b0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    mcbd_cell #(
      .IDX      (k),
      .MAX_DIM  (MAX_DIM),
      .CHANNELS (CHANNELS),
      .LAST     (k == NC - 1)
    ) u_cell (
      .clk              (clk),
      .rst_n            (rst_n),
      .clr_i            (cfg_wr && (cfg_ch.reg_index == REG_IMAGE_WIDTH ||
                                    cfg_ch.reg_index == REG_IMAGE_HEIGHT)),
      .img_w_i          (img_w_r),
      .img_h_i          (img_h_r),
      .tok_valid_i      (tok_valid[k]),
      .tok_tex_i        (tok_tex[k]),
      .next_will_emit_i (will_emit[k+1]),
      .slot_free_i      (slot_free),
      .will_emit_o      (will_emit[k]),
      .tok_valid_o      (tok_valid[k+1]),
      .tok_tex_o        (tok_tex[k+1]),
      .res_o            (res[k]),
      .stat_o           (stat[k])
    );
    assign emit_v[k] = stat[k].emit;
    assign done_v[k] = stat[k].done;
  end

  always_comb begin
    res_sel = '0;
    for (int k = 0; k < NC; k++) begin
      if (emit_v[k]) res_sel = res_sel | res[k];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.mip_level   = out_r.level;
  assign out_ch.texel_x     = out_r.x;
  assign out_ch.texel_y     = out_r.y;
  assign out_ch.out_red     = out_r.ch[0];
  assign out_ch.out_green   = out_r.ch[1];
  assign out_ch.out_blue    = out_r.ch[2];
  assign out_ch.out_alpha   = out_r.ch[3];
  assign out_ch.final_texel = out_r.final_texel;

  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(emit_v))
    else $error("more than one cell emitting");
  a_one_done: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(done_v))
    else $error("more than one cell done");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (|emit_v) |-> (!out_valid_r || out_ch.ready))
    else $error("result overwrites a pending transaction");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (|done_v) |-> busy_r)
    else $error("chain done while idle");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for mip_chain_box_downsample_rgba_unit: drives base texels and
// image sizes, predicts every mip texel of the cascade and checks the results in order.
// Depends on mcbd_pkg, mcbd_if and the RTL top level.
module tb_top;
  import mcbd_pkg::*;

  localparam int MIP_LEVELS  = DEF_MAX_LEVELS;
  localparam int HALF_DIM    = DEF_MAX_DIM / 2;
  localparam int DRAIN_WAIT  = 2 * DEF_MAX_LEVELS + 12;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_ITEMS  = 170;

  class mip_scoreboard;
    int unsigned img_w, img_h;
    int unsigned row_sums[MIP_LEVELS][HALF_DIM][MAX_CH];
    int unsigned left_hold[MIP_LEVELS][MAX_CH];
    int unsigned col_pos[MIP_LEVELS], row_pos[MIP_LEVELS];
    res_t expected_texels[$];
    int fails;

    function new();
      img_w = 1;
      img_h = 1;
      fails = 0;
      clear_pos();
    endfunction

    function void clear_pos();
      for (int k = 0; k < MIP_LEVELS; k++) begin
        col_pos[k] = 0;
        row_pos[k] = 0;
      end
    endfunction

    function int unsigned clamp_size(int unsigned v);
      if (v < 1) return 1;
      if (v > DEF_MAX_DIM) return DEF_MAX_DIM;
      return v;
    endfunction

    function int unsigned size_at(int unsigned d, int unsigned k);
      int unsigned r;
      r = d >> k;
      return (r != 0) ? r : 1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_IMAGE_WIDTH) img_w = clamp_size(data);
      else if (idx == REG_IMAGE_HEIGHT) img_h = clamp_size(data);
      else return;
      clear_pos();
    endfunction

    function void note_texel(chan_vec_t texel);
      int unsigned tex[MAX_CH], pair[MAX_CH], sum[MAX_CH];
      int unsigned m, levels, k, sw, sh, dw, dh, x, y, dx, dy;
      int first;
      res_t r;
      first = expected_texels.size();
      m = (img_w > img_h) ? img_w : img_h;
      levels = 0;
      while (m != 0) begin
        levels++;
        m >>= 1;
      end
      if (levels > MIP_LEVELS) levels = MIP_LEVELS;
      for (int c = 0; c < MAX_CH; c++) tex[c] = texel[c];
      k = 0;
      while (k + 1 < levels) begin
        sw = size_at(img_w, k);
        sh = size_at(img_h, k);
        dw = size_at(img_w, k + 1);
        dh = size_at(img_h, k + 1);
        x = col_pos[k];
        y = row_pos[k];
        if (x + 1 >= sw) begin
          col_pos[k] = 0;
          row_pos[k] = (y + 1 >= sh) ? 0 : y + 1;
        end else begin
          col_pos[k] = x + 1;
        end
        if (sw == 1) begin
          for (int c = 0; c < MAX_CH; c++) pair[c] = tex[c] << 1;
          dx = 0;
        end else begin
          if (x >= 2 * dw) break;
          if (x[0] == 1'b0) begin
            for (int c = 0; c < MAX_CH; c++) left_hold[k][c] = tex[c];
            break;
          end
          for (int c = 0; c < MAX_CH; c++) pair[c] = left_hold[k][c] + tex[c];
          dx = x >> 1;
        end
        if (dx >= HALF_DIM) break;
        if (sh == 1) begin
          for (int c = 0; c < MAX_CH; c++) sum[c] = pair[c] << 1;
          dy = 0;
        end else begin
          if (y >= 2 * dh) break;
          if (y[0] == 1'b0) begin
            for (int c = 0; c < MAX_CH; c++) row_sums[k][dx][c] = pair[c];
            break;
          end
          for (int c = 0; c < MAX_CH; c++) sum[c] = row_sums[k][dx][c] + pair[c];
          dy = y >> 1;
        end
        r = '0;
        r.level = LVL_W'(k + 1);
        r.x = TXY_W'(dx);
        r.y = TXY_W'(dy);
        for (int c = 0; c < MAX_CH; c++) begin
          tex[c] = (sum[c] >> 2) & 32'hFFFF;
          r.ch[c] = CH_W'(tex[c]);
        end
        expected_texels.push_back(r);
        k++;
      end
      if (expected_texels.size() > first)
        expected_texels[expected_texels.size() - 1].final_texel = 1'b1;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      fails++;
    endtask

    task check_texel(res_t got);
      res_t exp;
      if (expected_texels.size() == 0) begin
        report($sformatf("unexpected texel L%0d (%0d,%0d)", got.level, got.x, got.y));
        return;
      end
      exp = expected_texels.pop_front();
      if (got.level !== exp.level)
        report($sformatf("mip_level %0d, expected %0d", got.level, exp.level));
      if (got.x !== exp.x) report($sformatf("texel_x %0d, expected %0d", got.x, exp.x));
      if (got.y !== exp.y) report($sformatf("texel_y %0d, expected %0d", got.y, exp.y));
      for (int c = 0; c < MAX_CH; c++)
        if (got.ch[c] !== exp.ch[c])
          report($sformatf("channel %0d L%0d (%0d,%0d): %h, expected %h",
                           c, exp.level, exp.x, exp.y, got.ch[c], exp.ch[c]));
      if (got.final_texel !== exp.final_texel)
        report($sformatf("final_texel %0b, expected %0b", got.final_texel, exp.final_texel));
    endtask
  endclass

  logic clk;
  logic rst_n;
  mcbd_in_if  in_ch();
  mcbd_out_if out_ch();
  mcbd_cfg_if cfg_ch();

  mip_scoreboard sb;
  bit no_gaps;
  bit hold_req;
  bit hold_used;
  int unsigned cycles;
  int unsigned sent;

  mip_chain_box_downsample_rgba_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (no_gaps) return 0;
    p = $urandom_range(0, 19);
    if (p < 11) return 0;
    if (p < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    res_t got;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.reg_index, cfg_ch.wr_data);
      if (in_ch.valid && in_ch.ready)
        sb.note_texel({in_ch.chan_alpha, in_ch.chan_blue, in_ch.chan_green, in_ch.chan_red});
      if (out_ch.valid && out_ch.ready) begin
        got.level = out_ch.mip_level;
        got.x = out_ch.texel_x;
        got.y = out_ch.texel_y;
        got.ch = {out_ch.out_alpha, out_ch.out_blue, out_ch.out_green, out_ch.out_red};
        got.final_texel = out_ch.final_texel;
        sb.check_texel(got);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        n = 0;
        while (n < 300) begin
          @(posedge clk);
          n++;
        end
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n == 0) begin
          out_ch.ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  task automatic send_texel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                            logic [CH_W-1:0] b, logic [CH_W-1:0] a);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.chan_red <= r;
    in_ch.chan_green <= g;
    in_ch.chan_blue <= b;
    in_ch.chan_alpha <= a;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_random(int unsigned count);
    repeat (count)
      send_texel(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_texels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  initial begin
    int unsigned w, h, cnt;
    sb = new();
    no_gaps = 1'b0;
    hold_req = 1'b0;
    hold_used = 1'b0;
    cycles = 0;
    sent = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.chan_red <= '0;
    in_ch.chan_green <= '0;
    in_ch.chan_blue <= '0;
    in_ch.chan_alpha <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= REG_IMAGE_WIDTH;
    cfg_ch.wr_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 1x1 after reset: no mip texels
    send_texel('1, '1, '1, '1);
    set_size(2, 2);
    repeat (4) send_texel('1, '1, '1, '1);
    send_texel(0, 0, 0, 0);
    send_texel(0, 1, 0, 16'hFFFF);
    send_texel(0, 1, 16'hFFFF, 0);
    send_texel(3, 1, 16'hFFFF, 16'hFFFF);
    // zero width acts as one
    set_size(0, 2);
    send_texel(16'h8001, 16'h7FFF, 16'hFFFF, 0);
    send_texel(16'h0003, 16'hFFFF, 16'h0001, 16'hFFFF);
    // odd trailing column dropped
    set_size(3, 1);
    send_random(3);
    // oversized width clamps
    set_size(8191, 1);
    send_random(4);
    set_size(1, 4096);
    send_random(3);

    while (sent < RAND_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(9, 32);
        h = $urandom_range(1, 2);
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
      end
      if ($urandom_range(0, 1)) begin
        int unsigned t;
        t = w;
        w = h;
        h = t;
      end
      set_size(w, h);
      no_gaps = ($urandom_range(0, 3) == 0);
      cnt = w * h * $urandom_range(1, 2);
      if ($urandom_range(0, 5) == 0) cnt = $urandom_range(1, cnt);
      if (cnt > RAND_ITEMS - sent) cnt = RAND_ITEMS - sent;
      if (sent > 60 && !hold_used) begin
        hold_req = 1'b1;
        hold_used = 1'b1;
      end
      send_random(cnt);
      no_gaps = 1'b0;
    end

    wait_drained();
    if (sb.expected_texels.size() != 0)
      sb.report($sformatf("%0d texels never arrived", sb.expected_texels.size()));
    if (sb.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: mip_chain_box_downsample_rgba_unit.f
rtl/core/mcbd_pkg.sv
rtl/core/mcbd_if.sv
rtl/core/mcbd_cell.sv
rtl/core/mip_chain_box_downsample_rgba_unit.sv
tb/sv/tb_top.sv
